// ===== src/ecsa_pkg.sv =====
`timescale 1ns / 1ps

package ecsa_pkg;

  // History depth and derived widths
  localparam int HistDepth = 8;
  localparam int SlotW     = (HistDepth > 1) ? $clog2(HistDepth) : 1;
  localparam int FillW     = $clog2(HistDepth + 1);

  // Field widths
  localparam int CountW = 32;
  localparam int SpeedW = 37;
  localparam int PprW   = 16;
  localparam int MagW   = 15;
  localparam int ScaleW = 21;
  localparam int ProdW  = MagW + ScaleW;
  localparam int SumW   = SpeedW + $clog2(HistDepth);

  // Serial divider: dividend magnitude register and step counter
  localparam int DivW = SumW;
  localparam int CntW = $clog2(DivW);

  // Stream and register port widths
  localparam int InDataW = 8;
  localparam int OpW     = 2;
  localparam int OutW    = 2 * CountW + 2 * SpeedW;
  localparam int OutPadW = ((OutW + 7) / 8) * 8;
  localparam int AddrW   = 3;
  localparam int DataW   = 32;

  // Constants
  localparam logic signed [CountW-1:0] DeltaMax = 32'sd32767;
  localparam logic signed [CountW-1:0] DeltaMin = -32'sd32767;
  localparam logic [MagW-1:0]          MagMax   = 15'd32767;
  // 6000 rpm factor times 256 for 8 fraction bits
  localparam logic [ScaleW-1:0]        RpmScale = 21'd1536000;
  localparam logic [PprW-1:0]          PprReset = 16'd1024;

  typedef enum logic [OpW-1:0] {
    OpEdge  = 2'd0,
    OpTick  = 2'd1,
    OpClear = 2'd2,
    OpNone  = 2'd3
  } op_e;

  typedef enum logic {
    RegPpr    = 1'b0,
    RegInvert = 1'b1
  } reg_e;

  typedef enum logic [3:0] {
    StIdle,
    StMul,
    StDiv1,
    StRaw,
    StAdd,
    StLoad2,
    StDiv2,
    StAvg,
    StDone
  } state_e;

endpackage

// ===== src/encoder_count_speed_average.sv =====
`timescale 1ns / 1ps
// Quadrature encoder channel: position counter with moving-average speed.
// Input stream: one request per item. s_axis_tuser carries the operation
// (A edge, speed tick, clear, no-op), s_axis_tdata bit 0 the B level.
// Output stream: one result per request with position, delta over the last
// tick period, raw speed and averaged speed (rpm, 8 fraction bits).
// APB port: register 0 (0x0) pulses per revolution, register 1 (0x4) the
// direction invert bit; pready is always high, writes take effect at once.
// Edge, clear and no-op requests pass from acceptance through the done state
// into the output register. A speed tick first runs two divisions:
// raw speed and average each come from a bit-serial restoring divider that
// retires one quotient bit per cycle over DivW steps.
// Throughput: one request at a time; s_axis_tready rises again once the
// result is loaded into the output register and that register is free.
// A stalled receiver holds the result in the output register and keeps
// s_axis_tready low until it is taken.
// Reset clears position, delta, speeds and the history; pulses per rev
// returns to 1024 and the invert bit to 0.
module encoder_count_speed_average (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Request stream
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [0] b_level, [7:1] zero
  input  logic [ecsa_pkg::InDataW-1:0]     s_axis_tdata,
  // [1:0] operation
  input  logic [ecsa_pkg::OpW-1:0]         s_axis_tuser,
  // Result stream
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [31:0] position_count, [63:32] period_delta, [100:64] raw_speed,
  // [137:101] avg_speed, [143:138] zero
  output logic [ecsa_pkg::OutPadW-1:0]     m_axis_tdata,
  // Register port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [ecsa_pkg::AddrW-1:0]       paddr,
  input  logic [ecsa_pkg::DataW-1:0]       pwdata,
  output logic [ecsa_pkg::DataW-1:0]       prdata,
  output logic                             pready
);

  ecsa_pkg::state_e state_q, state_d;
  ecsa_pkg::op_e    op;
  ecsa_pkg::reg_e   reg_sel;

  logic in_req;
  logic out_load;
  logic cnt_zero;
  logic step_up;

  // Configuration
  logic [ecsa_pkg::PprW-1:0] ppr_q;
  logic [ecsa_pkg::PprW-1:0] ppr_eff;
  logic                      inv_q;

  // Channel state
  logic [ecsa_pkg::CountW-1:0]        pos_q;
  logic [ecsa_pkg::CountW-1:0]        tick_pos_q;
  logic [ecsa_pkg::CountW-1:0]        delta_q;
  logic [ecsa_pkg::SpeedW-1:0]        raw_q;
  logic [ecsa_pkg::SpeedW-1:0]        avg_q;
  logic signed [ecsa_pkg::SpeedW-1:0] hist_q [ecsa_pkg::HistDepth];
  logic signed [ecsa_pkg::SumW-1:0]   sum_q;
  logic [ecsa_pkg::SlotW-1:0]         slot_q;
  logic [ecsa_pkg::FillW-1:0]         fill_q;

  // Serial divider
  logic [ecsa_pkg::DivW-1:0] quo_q;
  logic [ecsa_pkg::PprW-1:0] rem_q;
  logic [ecsa_pkg::PprW-1:0] dsr_q;
  logic [ecsa_pkg::CntW-1:0] cnt_q;
  logic                      neg_q;
  logic [ecsa_pkg::PprW:0]   rem_sh;
  logic [ecsa_pkg::PprW:0]   rem_sub;
  logic                      rem_ge;
  logic [ecsa_pkg::DivW-1:0] quo_neg;

  // Speed path helpers
  logic signed [ecsa_pkg::CountW-1:0] delta_s;
  logic [ecsa_pkg::CountW-1:0]        delta_neg;
  logic [ecsa_pkg::MagW-1:0]          mag;
  logic [ecsa_pkg::ProdW-1:0]         prod;
  logic signed [ecsa_pkg::SumW-1:0]   hist_ext;
  logic signed [ecsa_pkg::SumW-1:0]   raw_ext;
  logic [ecsa_pkg::SumW-1:0]          sum_neg;

  // Output register
  logic                           m_valid_q;
  logic [ecsa_pkg::OutPadW-1:0]   m_data_q;

  assign op      = ecsa_pkg::op_e'(s_axis_tuser);
  assign in_req  = s_axis_tvalid && s_axis_tready;
  assign step_up = inv_q ? s_axis_tdata[0] : !s_axis_tdata[0];
  assign cnt_zero = (cnt_q == '0);

  //--------------------------------------------------------------------
  // Register port
  assign pready  = 1'b1;
  assign reg_sel = ecsa_pkg::reg_e'(paddr[2]);
  assign ppr_eff = (ppr_q == '0) ? ecsa_pkg::PprW'(1) : ppr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ppr_q <= ecsa_pkg::PprReset;
      inv_q <= 1'b0;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_sel)
        ecsa_pkg::RegPpr:    ppr_q <= pwdata[ecsa_pkg::PprW-1:0];
        ecsa_pkg::RegInvert: inv_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      ecsa_pkg::RegPpr:    prdata = ecsa_pkg::DataW'(ppr_q);
      ecsa_pkg::RegInvert: prdata = ecsa_pkg::DataW'(inv_q);
      default:             prdata = '0;
    endcase
  end

  //--------------------------------------------------------------------
  // Sequencer: next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ecsa_pkg::StIdle: begin
        if (in_req) begin
          state_d = (op == ecsa_pkg::OpTick) ? ecsa_pkg::StMul : ecsa_pkg::StDone;
        end
      end
      ecsa_pkg::StMul:   state_d = ecsa_pkg::StDiv1;
      ecsa_pkg::StDiv1:  if (cnt_zero) state_d = ecsa_pkg::StRaw;
      ecsa_pkg::StRaw:   state_d = ecsa_pkg::StAdd;
      ecsa_pkg::StAdd:   state_d = ecsa_pkg::StLoad2;
      ecsa_pkg::StLoad2: state_d = ecsa_pkg::StDiv2;
      ecsa_pkg::StDiv2:  if (cnt_zero) state_d = ecsa_pkg::StAvg;
      ecsa_pkg::StAvg:   state_d = ecsa_pkg::StDone;
      ecsa_pkg::StDone:  state_d = ecsa_pkg::StIdle;
      default:           state_d = ecsa_pkg::StIdle;
    endcase
  end

  // Sequencer: outputs
  always_comb begin
    s_axis_tready = (state_q == ecsa_pkg::StIdle) && (!m_valid_q || m_axis_tready);
    out_load      = (state_q == ecsa_pkg::StDone);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ecsa_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  //--------------------------------------------------------------------
  // Saturated delta magnitude and scaling
  assign delta_s   = delta_q;
  assign delta_neg = '0 - delta_q;

  always_comb begin
    if (delta_s > ecsa_pkg::DeltaMax || delta_s < ecsa_pkg::DeltaMin) begin
      mag = ecsa_pkg::MagMax;
    end else if (delta_q[ecsa_pkg::CountW-1]) begin
      mag = delta_neg[ecsa_pkg::MagW-1:0];
    end else begin
      mag = delta_q[ecsa_pkg::MagW-1:0];
    end
  end

  assign prod = mag * ecsa_pkg::RpmScale;

  //--------------------------------------------------------------------
  // Restoring divider, one quotient bit per cycle
  assign rem_sh  = {rem_q, quo_q[ecsa_pkg::DivW-1]};
  assign rem_ge  = (rem_sh >= {1'b0, dsr_q});
  assign rem_sub = rem_sh - {1'b0, dsr_q};
  assign quo_neg = '0 - quo_q;
  assign sum_neg = '0 - sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quo_q <= '0;
      rem_q <= '0;
      dsr_q <= ecsa_pkg::PprW'(1);
      cnt_q <= '0;
      neg_q <= 1'b0;
    end else begin
      unique case (state_q)
        ecsa_pkg::StMul: begin
          neg_q <= delta_q[ecsa_pkg::CountW-1];
          quo_q <= ecsa_pkg::DivW'(prod);
          dsr_q <= ppr_eff;
          rem_q <= '0;
          cnt_q <= ecsa_pkg::CntW'(ecsa_pkg::DivW - 1);
        end
        ecsa_pkg::StLoad2: begin
          neg_q <= sum_q[ecsa_pkg::SumW-1];
          quo_q <= sum_q[ecsa_pkg::SumW-1] ? sum_neg : sum_q;
          dsr_q <= ecsa_pkg::PprW'(fill_q);
          rem_q <= '0;
          cnt_q <= ecsa_pkg::CntW'(ecsa_pkg::DivW - 1);
        end
        ecsa_pkg::StDiv1, ecsa_pkg::StDiv2: begin
          rem_q <= rem_ge ? rem_sub[ecsa_pkg::PprW-1:0] : rem_sh[ecsa_pkg::PprW-1:0];
          quo_q <= {quo_q[ecsa_pkg::DivW-2:0], rem_ge};
          cnt_q <= cnt_q - 1'b1;
        end
        default: ;
      endcase
    end
  end

  //--------------------------------------------------------------------
  // Position, delta and history
  assign hist_ext = ecsa_pkg::SumW'(hist_q[slot_q]);
  assign raw_ext  = ecsa_pkg::SumW'(signed'(raw_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      tick_pos_q <= '0;
      delta_q    <= '0;
      raw_q      <= '0;
      avg_q      <= '0;
      sum_q      <= '0;
      slot_q     <= '0;
      fill_q     <= '0;
      for (int i = 0; i < ecsa_pkg::HistDepth; i++) begin
        hist_q[i] <= '0;
      end
    end else begin
      unique case (state_q)
        ecsa_pkg::StIdle: begin
          if (in_req) begin
            unique case (op)
              ecsa_pkg::OpEdge: begin
                pos_q <= step_up ? pos_q + 1'b1 : pos_q - 1'b1;
              end
              ecsa_pkg::OpTick: begin
                delta_q    <= pos_q - tick_pos_q;
                tick_pos_q <= pos_q;
              end
              ecsa_pkg::OpClear: begin
                pos_q      <= '0;
                tick_pos_q <= '0;
                delta_q    <= '0;
                raw_q      <= '0;
                avg_q      <= '0;
                sum_q      <= '0;
                slot_q     <= '0;
                fill_q     <= '0;
                for (int i = 0; i < ecsa_pkg::HistDepth; i++) begin
                  hist_q[i] <= '0;
                end
              end
              ecsa_pkg::OpNone: ;
              default: ;
            endcase
          end
        end
        // Raw speed with sign restored; drop the entry being replaced
        ecsa_pkg::StRaw: begin
          raw_q <= neg_q ? quo_neg[ecsa_pkg::SpeedW-1:0] : quo_q[ecsa_pkg::SpeedW-1:0];
          sum_q <= sum_q - hist_ext;
        end
        // Store new entry, advance ring pointer and fill count
        ecsa_pkg::StAdd: begin
          sum_q          <= sum_q + raw_ext;
          hist_q[slot_q] <= raw_q;
          slot_q <= (slot_q == ecsa_pkg::SlotW'(ecsa_pkg::HistDepth - 1)) ?
                    '0 : slot_q + 1'b1;
          if (fill_q != ecsa_pkg::FillW'(ecsa_pkg::HistDepth)) begin
            fill_q <= fill_q + 1'b1;
          end
        end
        ecsa_pkg::StAvg: begin
          avg_q <= neg_q ? quo_neg[ecsa_pkg::SpeedW-1:0] : quo_q[ecsa_pkg::SpeedW-1:0];
        end
        default: ;
      endcase
    end
  end

  //--------------------------------------------------------------------
  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_data_q <= ecsa_pkg::OutPadW'({avg_q, raw_q, delta_q, pos_q});
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

// ===== src/ecsa_checker.sv =====
`timescale 1ns / 1ps

module ecsa_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tvalid,
  input logic                         s_axis_tready,
  input logic [ecsa_pkg::OpW-1:0]     s_axis_tuser,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [ecsa_pkg::OutPadW-1:0] m_axis_tdata
);

  // No result is pending in the cycle after reset is seen
  assert property (@(posedge clk_i) !rst_ni |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  // A stalled result blocks new requests
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("request accepted while result stalled");

  // A stalled result holds its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // A clear request yields an all-zero result on the output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == ecsa_pkg::OpClear)
    |-> ##2 (m_axis_tvalid && (m_axis_tdata == '0)))
    else $error("clear did not give a zero result");

endmodule

bind encoder_count_speed_average ecsa_checker u_ecsa_checker (.*);
